### hw/rtl/bole_pkg.sv
package bole_pkg;

    localparam int DATA_W        = 32;
    localparam int KIND_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH_FRONT  = 4'd0,
        OP_PUSH_BACK   = 4'd1,
        OP_POP_FRONT   = 4'd2,
        OP_POP_BACK    = 4'd3,
        OP_SORTED_INS  = 4'd4,
        OP_REMOVE_ONE  = 4'd5,
        OP_REMOVE_ALL  = 4'd6,
        OP_EXISTS      = 4'd7,
        OP_CLEAR       = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Values produced by the head in one cycle, in list order; num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0]               num;
        logic signed [DATA_W-1:0] first;
        logic signed [DATA_W-1:0] second;
    } emit_t;

endpackage

### hw/rtl/bounded_ordered_list_engine_unit.sv
// Sequence: after its input transfer an operation walks every held entry through the
// head in the walk state, then registers its result in the finishing state.
// One operation at a time: no new transfer is taken until the result has been registered
// and the unit is idle again; a stalled earlier result holds the finishing state.
// Reset: aresetn is synchronous and active low; it empties the store and drops any
// pending result. The stored values themselves are not cleared.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,  // value [31:0]
    input  logic [3:0]    s_axis_tuser,  // kind [3:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,  // count [4:0], front_value [36:5],
                                         // back_value [68:37], zero pad [71:69]
    output logic [2:0]    m_axis_tuser   // status [1:0], found [2]
);

    // Counter width: counts run from zero up to DEPTH inclusive.
    localparam int CW = $clog2(DEPTH + 1);

    // The store is a row of cells, front at cell 0. Every operation walks the held
    // entries through the head: each cycle the whole row shifts left by one, the
    // head looks at the entry leaving cell 0 and writes zero, one or two values back
    // behind the entries still waiting. After the walk the new list sits at the
    // front of the row, and a push to the back is appended in the finishing cycle.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;     // entries held
    logic [CW-1:0]            rem_reg, rem_next;     // entries still to walk
    logic [CW-1:0]            tl_reg, tl_next;       // waiting plus rewritten entries
    op_t                      kind_reg, kind_next;
    logic signed [DATA_W-1:0] value_reg, value_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic                     out_found_reg, out_found_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic signed [DATA_W-1:0] out_front_reg, out_front_next;
    logic signed [DATA_W-1:0] out_back_reg, out_back_next;

    logic signed [DATA_W-1:0] cell_q [DEPTH];
    logic                     in_xfer;
    logic                     out_free;
    logic                     start;
    logic                     step;
    logic                     shift;
    logic                     full;
    logic                     ins_kind;
    logic                     pop_kind;
    logic                     search_kind;
    logic                     append;
    logic [CW-1:0]            wr_idx;
    logic [CW-1:0]            new_cnt;
    emit_t                    head_emit;
    emit_t                    cell_emit;
    logic                     head_found;
    logic                     head_ins_done;
    logic                     head_any;
    logic signed [DATA_W-1:0] head_first;
    logic signed [DATA_W-1:0] head_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign start         = in_xfer;
    assign step          = (state_reg == S_WALK);
    assign shift         = step;
    assign full          = (cnt_reg == CW'(DEPTH));

    assign ins_kind    = (kind_reg == OP_PUSH_FRONT) || (kind_reg == OP_PUSH_BACK) ||
                         (kind_reg == OP_SORTED_INS);
    assign pop_kind    = (kind_reg == OP_POP_FRONT) || (kind_reg == OP_POP_BACK);
    assign search_kind = (kind_reg == OP_REMOVE_ONE) || (kind_reg == OP_REMOVE_ALL) ||
                         (kind_reg == OP_EXISTS);

    // An insertion that the walk did not place (push back, push front into an empty
    // store, sorted insert past every entry) goes behind the rewritten list.
    assign append = (state_reg == S_FIN) && ins_kind && !full && !head_ins_done;

    bole_head u_head (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .step       (step),
        .kind       (kind_reg),
        .value      (value_reg),
        .head_in    (cell_q[0]),
        .first_step (rem_reg == cnt_reg),
        .last_step  (rem_reg == CW'(1)),
        .full       (full),
        .emit       (head_emit),
        .found      (head_found),
        .ins_done   (head_ins_done),
        .any_emit   (head_any),
        .first_val  (head_first),
        .last_val   (head_last)
    );

    // During the walk the head writes just behind the waiting and rewritten entries, which sit
    // one place further left after this cycle's shift; when finishing, the append lands
    // right after the rewritten list.
    always_comb begin
        cell_emit = head_emit;
        wr_idx    = tl_reg - CW'(1);
        if (state_reg != S_WALK) begin
            cell_emit.num    = append ? 2'd1 : 2'd0;
            cell_emit.first  = value_reg;
            cell_emit.second = value_reg;
            wr_idx           = tl_reg;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] right_in;
        if (i == DEPTH - 1) begin : g_last
            assign right_in = cell_q[i];
        end else begin : g_mid
            assign right_in = cell_q[i+1];
        end
        bole_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .aclk     (aclk),
            .shift    (shift),
            .right_in (right_in),
            .wr_idx   (wr_idx),
            .emit     (cell_emit),
            .data_out (cell_q[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        tl_next         = tl_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        new_cnt         = tl_reg + (append ? CW'(1) : CW'(0));
        if (kind_reg == OP_CLEAR) begin
            new_cnt = '0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    kind_next  = op_t'(s_axis_tuser);
                    value_next = s_axis_tdata;
                    rem_next   = cnt_reg;
                    tl_next    = cnt_reg;
                    state_next = (cnt_reg == '0) ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                rem_next = rem_reg - CW'(1);
                tl_next  = tl_reg - CW'(1) + CW'(head_emit.num);
                if (rem_reg == CW'(1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cnt_next        = new_cnt;
                    out_valid_next  = 1'b1;
                    out_found_next  = head_found;
                    out_count_next  = COUNT_W'(new_cnt);
                    out_status_next = ST_OK;
                    if (ins_kind && full) begin
                        out_status_next = ST_FULL;
                    end else if ((pop_kind || search_kind) && (cnt_reg == '0)) begin
                        out_status_next = ST_EMPTY;
                    end else if (search_kind && !head_found) begin
                        out_status_next = ST_MISS;
                    end
                    if (new_cnt == '0) begin
                        out_front_next = '0;
                        out_back_next  = '0;
                    end else begin
                        out_front_next = head_any ? head_first : value_reg;
                        out_back_next  = append ? value_reg : head_last;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            tl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            tl_reg        <= tl_next;
            out_valid_reg <= out_valid_next;
        end
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_back_reg, out_front_reg, out_count_reg};
    assign m_axis_tuser  = {out_found_reg, out_status_reg};

    // The store never claims more entries than it has cells.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    // The rewritten list plus the waiting entries never outgrow the row.
    a_tl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (tl_reg <= CW'(DEPTH)) && (rem_reg != '0))
        else $error("walk bookkeeping out of range");

    // A transfer into a non-empty store starts a walk; into an empty one it finishes.
    a_start_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> ((state_reg == S_WALK) == ($past(cnt_reg) != '0)))
        else $error("walk did not start as expected");

    // The count only changes in the cycle a result is produced.
    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_FIN) |=> $stable(cnt_reg))
        else $error("fill count changed outside finishing cycle");

endmodule

### hw/rtl/bole_cell.sv
module bole_cell import bole_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                     aclk,
    input  logic                     shift,
    input  logic signed [DATA_W-1:0] right_in,
    input  logic [CW-1:0]            wr_idx,
    input  emit_t                    emit,
    output logic signed [DATA_W-1:0] data_out
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit_first;
    logic                     hit_second;

    // A cell takes its right neighbor's value on a shift, unless one of the
    // produced values lands here.
    always_comb begin
        hit_first  = (emit.num != 2'd0) && (wr_idx == CW'(INDEX));
        hit_second = (emit.num == 2'd2) &&
                     (({1'b0, wr_idx} + (CW+1)'(1)) == (CW+1)'(INDEX));
        data_next  = shift ? right_in : data_reg;
        if (hit_first) begin
            data_next = emit.first;
        end else if (hit_second) begin
            data_next = emit.second;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### hw/rtl/bole_head.sv
module bole_head import bole_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     step,
    input  op_t                      kind,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] head_in,
    input  logic                     first_step,
    input  logic                     last_step,
    input  logic                     full,
    output emit_t                    emit,
    output logic                     found,
    output logic                     ins_done,
    output logic                     any_emit,
    output logic signed [DATA_W-1:0] first_val,
    output logic signed [DATA_W-1:0] last_val
);

    logic                     found_reg, found_next;
    logic                     ins_reg, ins_next;
    logic                     rm_reg, rm_next;
    logic                     any_reg, any_next;
    logic signed [DATA_W-1:0] first_reg, first_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic                     match;

    always_comb begin
        match      = (head_in == value);
        emit.num   = 2'd1;
        emit.first = head_in;
        emit.second = head_in;
        ins_next   = ins_reg;
        rm_next    = rm_reg;
        unique case (kind)
            OP_PUSH_FRONT: begin
                if (!full && !ins_reg) begin
                    emit.num   = 2'd2;
                    emit.first = value;
                    ins_next   = 1'b1;
                end
            end
            OP_SORTED_INS: begin
                if (!full && !ins_reg && !(head_in < value)) begin
                    emit.num   = 2'd2;
                    emit.first = value;
                    ins_next   = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (first_step) begin
                    emit.num = 2'd0;
                end
            end
            OP_POP_BACK: begin
                if (last_step) begin
                    emit.num = 2'd0;
                end
            end
            OP_REMOVE_ONE: begin
                if (match && !rm_reg) begin
                    emit.num = 2'd0;
                    rm_next  = 1'b1;
                end
            end
            OP_REMOVE_ALL: begin
                if (match) begin
                    emit.num = 2'd0;
                end
            end
            default: begin
            end
        endcase
        if (!step) begin
            emit.num = 2'd0;
            ins_next = ins_reg;
            rm_next  = rm_reg;
        end

        found_next = found_reg | (step & match);
        any_next   = any_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (emit.num != 2'd0) begin
            any_next  = 1'b1;
            if (!any_reg) begin
                first_next = emit.first;
            end
            last_next = (emit.num == 2'd2) ? emit.second : emit.first;
        end
        if (start) begin
            found_next = 1'b0;
            ins_next   = 1'b0;
            rm_next    = 1'b0;
            any_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            ins_reg   <= 1'b0;
            rm_reg    <= 1'b0;
            any_reg   <= 1'b0;
        end else begin
            found_reg <= found_next;
            ins_reg   <= ins_next;
            rm_reg    <= rm_next;
            any_reg   <= any_next;
        end
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign found     = found_reg;
    assign ins_done  = ins_reg;
    assign any_emit  = any_reg;
    assign first_val = first_reg;
    assign last_val  = last_reg;

endmodule
